[hw/rtl/dcw_pkg.sv]
// Shared constants and types for the descriptor chain walker.
`default_nettype none

package dcw_pkg;

   // Walk geometry
   localparam int SLOTS_PER_GROUP = 4;
   localparam int WORDS_DELIVERED = 4;
   localparam int SLOT_CNT_W      = $clog2(SLOTS_PER_GROUP + 1);
   localparam logic [31:0] GROUP_BYTES = 32'(SLOTS_PER_GROUP * 4);

   // Descriptor word decode
   localparam int          STOP_BIT    = 31;
   localparam int          JUMP_BIT    = 30;
   localparam logic [31:0] TARGET_MASK = 32'h3fff_ffff;

   // Step limit register
   localparam int          LIMIT_W     = 24;
   localparam int          STEP_W      = 25;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd400000;

   // Operation codes carried on req_tuser
   localparam logic OP_START   = 1'b0;
   localparam logic OP_DELIVER = 1'b1;

   // Result transaction, last field in the lowest bits
   typedef struct packed {
      logic [3:0]        pad;
      logic [STEP_W-1:0] step_count;
      logic              limit_hit;
      logic [31:0]       back_jump_count;
      logic [31:0]       jump_count;
      logic [31:0]       page_count;
      logic [31:0]       stop_addr;
      logic              stop_found;
      logic              done_res;
      logic [31:0]       fetch_addr;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

`default_nettype wire

[hw/rtl/dma_descriptor_chain_walker_core.sv]
// Descriptor chain walker: scans fetched descriptor groups and issues next fetch addresses.
//
// Usage: send a start transaction (req_tuser = 0) carrying the chain address in
// req_tdata[31:0]; the response gives that address as the first fetch address.
// Then deliver each fetched 16-byte group (req_tuser = 1, words in req_tdata
// [63:32] .. [159:128]); each response gives the next group to fetch, or done_res
// set once a STOP word or the step limit ended the walk. Every request yields
// exactly one response, in order.
// The response is registered: it enters the response register, or the skid entry while that register is held.
// Throughput: one request per cycle while req_tready is high; the four-slot scan of a group is one level
// of priority logic between the walk state registers and the response register.
// Stalls: a response register plus one skid entry sit on the output, so one more
// request is taken while a response waits; req_tready drops when both are full.
// Reset (synchronous): the walk is idle (done), all counts are zero, the step
// limit returns to 400000, and no response is pending. The user writes the step limit
// via csr_write_enable / csr_write_data only while idle; the block does not enforce it.
`default_nettype none

module dma_descriptor_chain_walker_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // configuration
   input  wire logic                       csr_write_enable,
   input  wire logic [dcw_pkg::LIMIT_W-1:0] csr_write_data,   // step_limit
   // request channel
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [159:0]               req_tdata,  // start_addr, word_zero, word_one,
                                                       // word_two, word_three
   input  wire logic                       req_tuser,  // operation
   // response channel
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [191:0]               rsp_tdata   // fetch_addr, done_res, stop_found,
                                                       // stop_addr, page_count, jump_count,
                                                       // back_jump_count, limit_hit,
                                                       // step_count, zero pad
);

   // Configuration and walk state
   logic [dcw_pkg::LIMIT_W-1:0] step_limit_ff;
   logic [31:0]                 group_addr_ff,  group_addr_in;
   logic [31:0]                 pages_ff,       pages_in;
   logic [31:0]                 jumps_ff,       jumps_in;
   logic [31:0]                 back_jumps_ff,  back_jumps_in;
   logic [dcw_pkg::STEP_W-1:0]  steps_ff,       steps_in;
   logic                        walk_done_ff,   walk_done_in;
   logic                        stop_seen_ff,   stop_seen_in;
   logic                        limit_seen_ff,  limit_seen_in;

   // Output register and skid entry
   dcw_pkg::rsp_type            out_ff,  skid_ff;
   logic                        out_valid_ff, skid_valid_ff;
   dcw_pkg::rsp_type            rsp_new;

   logic                        req_accept;
   logic                        out_free;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // Start a walk, or scan one delivered group slot by slot, first terminating slot wins
   always_comb begin
      logic [31:0]                    words [dcw_pkg::WORDS_DELIVERED];
      logic [31:0]                    w;
      logic [31:0]                    tgt;
      logic                           active;
      logic                           jump_taken;
      logic [dcw_pkg::SLOT_CNT_W-1:0] page_add;
      logic [dcw_pkg::STEP_W-1:0]     steps;
      logic [32:0]                    page_sum;

      words[0] = req_tdata[63:32];
      words[1] = req_tdata[95:64];
      words[2] = req_tdata[127:96];
      words[3] = req_tdata[159:128];

      group_addr_in = group_addr_ff;
      pages_in      = pages_ff;
      jumps_in      = jumps_ff;
      back_jumps_in = back_jumps_ff;
      steps_in      = steps_ff;
      walk_done_in  = walk_done_ff;
      stop_seen_in  = stop_seen_ff;
      limit_seen_in = limit_seen_ff;

      active     = 1'b1;
      jump_taken = 1'b0;
      tgt        = '0;
      page_add   = '0;
      steps      = steps_ff;
      page_sum   = '0;

      unique case (req_tuser)
         dcw_pkg::OP_START: begin
            group_addr_in = req_tdata[31:0];
            pages_in      = '0;
            jumps_in      = '0;
            back_jumps_in = '0;
            steps_in      = '0;
            walk_done_in  = 1'b0;
            stop_seen_in  = 1'b0;
            limit_seen_in = 1'b0;
         end
         dcw_pkg::OP_DELIVER: begin
            if (!walk_done_ff) begin
               for (int s = 0; s < dcw_pkg::SLOTS_PER_GROUP; s++) begin
                  if (s < dcw_pkg::WORDS_DELIVERED) begin
                     w = words[2'(s)];
                  end else begin
                     w = '0;
                  end
                  if (active) begin
                     if (steps >= {1'b0, step_limit_ff}) begin
                        limit_seen_in = 1'b1;
                        walk_done_in  = 1'b1;
                        active        = 1'b0;
                     end else if (w[dcw_pkg::STOP_BIT]) begin
                        stop_seen_in = 1'b1;
                        walk_done_in = 1'b1;
                        active       = 1'b0;
                     end else if (w[dcw_pkg::JUMP_BIT]) begin
                        tgt        = w & dcw_pkg::TARGET_MASK;
                        jump_taken = 1'b1;
                        active     = 1'b0;
                     end else if (w != '0) begin
                        page_add = page_add + 1'b1;
                     end
                     steps = steps + 1'b1;
                  end
               end
               steps_in = steps;

               // Saturating page count
               page_sum = {1'b0, pages_ff} + 33'(page_add);
               pages_in = page_sum[32] ? '1 : page_sum[31:0];

               if (jump_taken) begin
                  jumps_in = (&jumps_ff) ? jumps_ff : jumps_ff + 1'b1;
                  if (tgt <= group_addr_ff) begin
                     back_jumps_in = (&back_jumps_ff) ? back_jumps_ff : back_jumps_ff + 1'b1;
                  end
                  group_addr_in = tgt;
               end else if (active) begin
                  group_addr_in = group_addr_ff + dcw_pkg::GROUP_BYTES;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Build the response from the updated state
   always_comb begin
      rsp_new                 = '0;
      rsp_new.fetch_addr      = walk_done_in ? '0 : group_addr_in;
      rsp_new.done_res        = walk_done_in;
      rsp_new.stop_found      = stop_seen_in;
      rsp_new.stop_addr       = stop_seen_in ? group_addr_in : '0;
      rsp_new.page_count      = pages_in;
      rsp_new.jump_count      = jumps_in;
      rsp_new.back_jump_count = back_jumps_in;
      rsp_new.limit_hit       = limit_seen_in;
      rsp_new.step_count      = steps_in;
   end

   // Hold the step limit
   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff <= dcw_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         step_limit_ff <= csr_write_data;
      end
   end

   // Advance the walk state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         group_addr_ff <= '0;
         pages_ff      <= '0;
         jumps_ff      <= '0;
         back_jumps_ff <= '0;
         steps_ff      <= '0;
         walk_done_ff  <= 1'b1;
         stop_seen_ff  <= 1'b0;
         limit_seen_ff <= 1'b0;
      end else if (req_accept) begin
         group_addr_ff <= group_addr_in;
         pages_ff      <= pages_in;
         jumps_ff      <= jumps_in;
         back_jumps_ff <= back_jumps_in;
         steps_ff      <= steps_in;
         walk_done_ff  <= walk_done_in;
         stop_seen_ff  <= stop_seen_in;
         limit_seen_ff <= limit_seen_in;
      end
   end

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_accept) begin
            out_ff <= rsp_new;
         end
      end else if (req_accept) begin
         skid_ff <= rsp_new;
      end
   end

   // Checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a response while the output register is empty");

   a_done_no_fetch: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.done_res |-> out_ff.fetch_addr == '0)
      else $error("finished walk reports a fetch address");

   a_end_cause_single: assert property (@(posedge clock) disable iff (reset)
      !(stop_seen_ff && limit_seen_ff))
      else $error("walk ended by both stop and step limit");

   a_walking_no_cause: assert property (@(posedge clock) disable iff (reset)
      !walk_done_ff |-> !stop_seen_ff && !limit_seen_ff)
      else $error("walk in progress carries an end cause");

   // A limit end always reports more examinations than the limit allows
   a_limit_step_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && !walk_done_ff && limit_seen_in |=>
      steps_ff > {1'b0, $past(step_limit_ff)})
      else $error("step limit end reports wrong step count");

endmodule

`default_nettype wire
